[sv/clpg_pkg.sv]
// Shared types and constants for the CPU load power governor.
// Holds configuration register codes, the shared adder op codes and the
// structs passed between the sequencer and the dwell tracker. No dependencies.
package clpg_pkg;

  localparam int CountWidth   = 64;
  localparam int AluWidth     = 72;
  localparam int LoadWidth    = 7;
  localparam int TickWidth    = 16;
  localparam int CpuWidth     = 2;
  localparam int ConnWidth    = 5;
  localparam int CfgIdxWidth  = 2;
  localparam int CfgDataWidth = 16;
  localparam int QuotBits     = 7;

  localparam logic [CpuWidth-1:0]  MaxCpus      = 2'd2;
  localparam logic [LoadWidth-1:0] FullLoad     = 7'd100;
  localparam logic [TickWidth-1:0] LowDefault   = 16'd5;
  localparam logic [TickWidth-1:0] HighDefault  = 16'd10;
  localparam logic [TickWidth-1:0] OffDefault   = 16'd10;
  localparam logic [TickWidth-1:0] StbyDefault  = 16'd60;

  // Configuration register index codes
  typedef enum logic [CfgIdxWidth-1:0] {
    REG_LOW_THRESHOLD      = 2'd0,
    REG_HIGH_THRESHOLD     = 2'd1,
    REG_OFFLINE_IDLE_TICKS = 2'd2,
    REG_STANDBY_IDLE_TICKS = 2'd3
  } cfg_reg_t;

  // Shared adder operation
  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_t;

  typedef struct packed {
    logic [LoadWidth-1:0] low_threshold;
    logic [LoadWidth-1:0] high_threshold;
    logic [TickWidth-1:0] offline_idle_ticks;
    logic [TickWidth-1:0] standby_idle_ticks;
  } cfg_t;

  typedef struct packed {
    logic                 update;
    logic [LoadWidth-1:0] load;
    logic [CpuWidth-1:0]  cpus;
    logic [ConnWidth-1:0] conns;
  } dwell_req_t;

  typedef struct packed {
    logic cpu_off;
    logic cpu_on;
    logic standby;
  } dwell_rsp_t;

endpackage

[sv/clpg_alu.sv]
// Shared 72-bit add/subtract unit of the load governor.
// Used by the sequencer for deltas, compares, the x100 product and division.
// Depends on clpg_pkg.
module clpg_alu import clpg_pkg::*; (
  input  alu_op_t             op,
  input  logic [AluWidth-1:0] a,
  input  logic [AluWidth-1:0] b,
  output logic [AluWidth-1:0] result
);

  always_comb begin
    unique case (op)
      ALU_ADD: result = a + b;
      ALU_SUB: result = a - b;
      default: result = a + b;
    endcase
  end

endmodule

[sv/clpg_dwell.sv]
// Idle and busy dwell counters with the offline, online and standby decisions.
// Counters saturate and are cleared by a standby request.
// Depends on clpg_pkg.
module clpg_dwell import clpg_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  dwell_req_t req,
  output dwell_rsp_t rsp
);

  logic [TickWidth-1:0] idle_ticks, busy_ticks;
  logic [TickWidth-1:0] idle_next, busy_next;
  logic [TickWidth-1:0] idle_inc, busy_inc, idle_mid, busy_mid, idle_upd, busy_upd;
  logic                 is_idle, is_busy;

  // Dwell update: idle test first, then busy test
  always_comb begin
    is_idle  = req.load < cfg.low_threshold;
    is_busy  = req.load > cfg.high_threshold;
    idle_inc = (idle_ticks == '1) ? idle_ticks : idle_ticks + 1'b1;
    idle_mid = is_idle ? idle_inc : '0;
    busy_mid = is_idle ? '0 : busy_ticks;
    busy_inc = (busy_mid == '1) ? busy_mid : busy_mid + 1'b1;
    busy_upd = is_busy ? busy_inc : '0;
    idle_upd = is_busy ? '0 : idle_mid;

    rsp.cpu_off = (idle_upd > cfg.offline_idle_ticks) && (req.cpus > 2'd1);
    rsp.cpu_on  = (busy_upd > 16'd1) && (req.cpus < MaxCpus);
    rsp.standby = (idle_upd > cfg.standby_idle_ticks) && (req.cpus != '0)
                  && (req.conns == '0);

    idle_next = rsp.standby ? '0 : idle_upd;
    busy_next = rsp.standby ? '0 : busy_upd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idle_ticks <= '0;
      busy_ticks <= '0;
    end else if (req.update) begin
      idle_ticks <= idle_next;
      busy_ticks <= busy_next;
    end
  end

endmodule

[sv/cpu_load_power_governor.sv]
// CPU load power governor: sequencer, configuration registers, output register.
// Instantiates clpg_alu (shared adder) and clpg_dwell (dwell counters).
// Depends on clpg_pkg.
//
// Usage: one transaction on the input channel (in_valid / in_stall) per tick
// carries the cumulative total and busy counters, CPUs online and connection
// count. One result transaction follows on the output channel (out_valid /
// out_stall) for every input.
// The first tick after reset only stores the counters and returns load 0 with
// zero_interval set. Later ticks run through one shared 72-bit adder: two
// delta subtractions, a saturation compare, two adds forming the busy delta
// times 100, and seven restoring division steps. A zero total delta or a busy
// delta not below the total delta finishes straight after the compare and
// skips the product and the division. The block holds in_stall high until
// the result is in the output register, so one item is in flight at a time.
// If the receiver stalls, the result stays in the output register and the
// next item may be accepted; its result waits until the register is taken.
// Synchronous reset restores register defaults (5, 10, 10, 60), clears the
// stored counters, dwell counters and the primed flag, and empties the output.
// Configuration writes through cfg_write / cfg_index / cfg_data take effect
// at the next edge.
module cpu_load_power_governor import clpg_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_write,
  input  logic [CfgIdxWidth-1:0]  cfg_index,
  input  logic [CfgDataWidth-1:0] cfg_data,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [CountWidth-1:0]   total_count,
  input  logic [CountWidth-1:0]   busy_count,
  input  logic [CpuWidth-1:0]     cpus_online,
  input  logic [ConnWidth-1:0]    connection_count,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [LoadWidth-1:0]    load_percent,
  output logic                    cpu_off_request,
  output logic                    cpu_on_request,
  output logic                    standby_request,
  output logic                    zero_interval
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SUB_TOTAL,
    S_SUB_BUSY,
    S_COMPARE,
    S_MUL_A,
    S_MUL_B,
    S_DIVIDE,
    S_FINISH
  } state_t;

  state_t state;
  cfg_t   cfg;

  // Latched transaction and stored counters
  logic [CountWidth-1:0] total_q, busy_q, prev_total, prev_busy;
  logic [CpuWidth-1:0]   cpus_q;
  logic [ConnWidth-1:0]  conns_q;
  logic                  primed;
  logic                  priming_tick;

  // Datapath registers
  logic [CountWidth-1:0] delta_total, delta_busy;
  logic [AluWidth-1:0]   acc;
  logic [LoadWidth-1:0]  load;
  logic                  zero_flag;
  logic [2:0]            step;

  // Shared adder operands
  alu_op_t             alu_op;
  logic [AluWidth-1:0] alu_a, alu_b, alu_res;
  logic [AluWidth-1:0] total_ext, busy_ext, dt_ext, db_ext;

  dwell_req_t dreq;
  dwell_rsp_t drsp;
  logic       out_free;

  assign total_ext = {{(AluWidth-CountWidth){1'b0}}, total_q};
  assign busy_ext  = {{(AluWidth-CountWidth){1'b0}}, busy_q};
  assign dt_ext    = {{(AluWidth-CountWidth){1'b0}}, delta_total};
  assign db_ext    = {{(AluWidth-CountWidth){1'b0}}, delta_busy};

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  // Operand selection for the shared adder
  always_comb begin
    alu_op = ALU_SUB;
    alu_a  = acc;
    alu_b  = dt_ext << step;
    unique case (state)
      S_SUB_TOTAL: begin
        alu_a = total_ext;
        alu_b = {{(AluWidth-CountWidth){1'b0}}, prev_total};
      end
      S_SUB_BUSY: begin
        alu_a = busy_ext;
        alu_b = {{(AluWidth-CountWidth){1'b0}}, prev_busy};
      end
      S_COMPARE: begin
        alu_a = db_ext;
        alu_b = dt_ext;
      end
      S_MUL_A: begin
        alu_op = ALU_ADD;
        alu_a  = db_ext << 6;
        alu_b  = db_ext << 5;
      end
      S_MUL_B: begin
        alu_op = ALU_ADD;
        alu_a  = acc;
        alu_b  = db_ext << 2;
      end
      default: begin
        alu_op = ALU_SUB;
        alu_a  = acc;
        alu_b  = dt_ext << step;
      end
    endcase
  end

  clpg_alu u_alu (
    .op     (alu_op),
    .a      (alu_a),
    .b      (alu_b),
    .result (alu_res)
  );

  // Dwell update happens as the result is written out
  always_comb begin
    dreq.update = (state == S_FINISH) && out_free && !priming_tick;
    dreq.load   = load;
    dreq.cpus   = cpus_q;
    dreq.conns  = conns_q;
  end

  clpg_dwell u_dwell (
    .clk (clk),
    .rst (rst),
    .cfg (cfg),
    .req (dreq),
    .rsp (drsp)
  );

  // Sequencer, configuration and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state                  <= S_IDLE;
      primed                 <= 1'b0;
      prev_total             <= '0;
      prev_busy              <= '0;
      out_valid              <= 1'b0;
      cfg.low_threshold      <= LowDefault[LoadWidth-1:0];
      cfg.high_threshold     <= HighDefault[LoadWidth-1:0];
      cfg.offline_idle_ticks <= OffDefault;
      cfg.standby_idle_ticks <= StbyDefault;
    end else begin
      if (cfg_write) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_LOW_THRESHOLD:      cfg.low_threshold      <= cfg_data[LoadWidth-1:0];
          REG_HIGH_THRESHOLD:     cfg.high_threshold     <= cfg_data[LoadWidth-1:0];
          REG_OFFLINE_IDLE_TICKS: cfg.offline_idle_ticks <= cfg_data;
          REG_STANDBY_IDLE_TICKS: cfg.standby_idle_ticks <= cfg_data;
          default: ;
        endcase
      end

      // Output valid: load a new result, or drop the one just taken
      if (state == S_FINISH && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            total_q <= total_count;
            busy_q  <= busy_count;
            cpus_q  <= cpus_online;
            conns_q <= connection_count;
            if (!primed) begin
              priming_tick <= 1'b1;
              primed       <= 1'b1;
              prev_total   <= total_count;
              prev_busy    <= busy_count;
              load         <= '0;
              zero_flag    <= 1'b1;
              state        <= S_FINISH;
            end else begin
              priming_tick <= 1'b0;
              state        <= S_SUB_TOTAL;
            end
          end
        end
        S_SUB_TOTAL: begin
          delta_total <= alu_res[CountWidth-1:0];
          prev_total  <= total_q;
          state       <= S_SUB_BUSY;
        end
        S_SUB_BUSY: begin
          delta_busy <= alu_res[CountWidth-1:0];
          prev_busy  <= busy_q;
          state      <= S_COMPARE;
        end
        S_COMPARE: begin
          priority if (delta_total == '0) begin
            load      <= '0;
            zero_flag <= 1'b1;
            state     <= S_FINISH;
          end else if (!alu_res[AluWidth-1]) begin
            load      <= FullLoad;
            zero_flag <= 1'b0;
            state     <= S_FINISH;
          end else begin
            zero_flag <= 1'b0;
            state     <= S_MUL_A;
          end
        end
        S_MUL_A: begin
          acc   <= alu_res;
          state <= S_MUL_B;
        end
        S_MUL_B: begin
          acc   <= alu_res;
          load  <= '0;
          step  <= 3'(QuotBits - 1);
          state <= S_DIVIDE;
        end
        S_DIVIDE: begin
          // Restoring step: keep the difference when it does not go negative
          if (!alu_res[AluWidth-1]) begin
            acc  <= alu_res;
            load <= {load[LoadWidth-2:0], 1'b1};
          end else begin
            load <= {load[LoadWidth-2:0], 1'b0};
          end
          if (step == '0) begin
            state <= S_FINISH;
          end else begin
            step <= step - 3'd1;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            load_percent    <= load;
            zero_interval   <= zero_flag;
            cpu_off_request <= !priming_tick && drsp.cpu_off;
            cpu_on_request  <= !priming_tick && drsp.cpu_on;
            standby_request <= !priming_tick && drsp.standby;
            state           <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[test/tb.sv]
// Testbench for cpu_load_power_governor: directed and random ticks with a scoreboard
// that predicts load, dwell counters and requests. Depends on clpg_pkg and the block RTL.
`timescale 1ns / 1ps

module tb;
  import clpg_pkg::*;

  // One result transaction of the block
  typedef struct packed {
    logic [LoadWidth-1:0] load;
    logic                 cpu_off;
    logic                 cpu_on;
    logic                 standby;
    logic                 zero;
  } decision_t;

  // Load patterns used to build tick sequences
  typedef enum int {
    RG_IDLE,
    RG_BUSY,
    RG_MID,
    RG_ZERO,
    RG_NOISE
  } regime_t;

  // Governor state, configuration and the queue of decisions still to come
  class governor_scoreboard;
    bit [LoadWidth-1:0]  low_thr  = LowDefault[LoadWidth-1:0];
    bit [LoadWidth-1:0]  high_thr = HighDefault[LoadWidth-1:0];
    bit [TickWidth-1:0]  off_ticks  = OffDefault;
    bit [TickWidth-1:0]  stby_ticks = StbyDefault;
    bit [CountWidth-1:0] last_total;
    bit [CountWidth-1:0] last_busy;
    bit [TickWidth-1:0]  idle_cnt;
    bit [TickWidth-1:0]  busy_cnt;
    bit                  primed;
    decision_t           decisions_due[$];
    int unsigned         mismatches;

    function void set_reg(cfg_reg_t idx, bit [CfgDataWidth-1:0] data);
      case (idx)
        REG_LOW_THRESHOLD:      low_thr    = data[LoadWidth-1:0];
        REG_HIGH_THRESHOLD:     high_thr   = data[LoadWidth-1:0];
        REG_OFFLINE_IDLE_TICKS: off_ticks  = data;
        REG_STANDBY_IDLE_TICKS: stby_ticks = data;
        default: ;
      endcase
    endfunction

    // Predict the decision for one accepted tick
    function void note_tick(bit [CountWidth-1:0] total, bit [CountWidth-1:0] busy,
                            bit [CpuWidth-1:0] cpus, bit [ConnWidth-1:0] conns);
      decision_t           d;
      bit [CountWidth-1:0] dt;
      bit [CountWidth-1:0] db;
      bit [127:0]          quot;
      d = '0;
      if (!primed) begin
        last_total = total;
        last_busy  = busy;
        primed     = 1'b1;
        d.zero     = 1'b1;
        decisions_due.push_back(d);
        return;
      end
      dt = total - last_total;
      db = busy - last_busy;
      last_total = total;
      last_busy  = busy;
      if (dt == '0) begin
        d.zero = 1'b1;
      end else if (db >= dt) begin
        d.load = FullLoad;
      end else begin
        quot   = ({64'd0, db} * 128'd100) / {64'd0, dt};
        d.load = quot[LoadWidth-1:0];
      end
      // dwell counters, idle side first, both saturating
      if (d.load < low_thr) begin
        if (idle_cnt != '1) idle_cnt++;
        busy_cnt = '0;
      end else begin
        idle_cnt = '0;
      end
      if (d.load > high_thr) begin
        if (busy_cnt != '1) busy_cnt++;
        idle_cnt = '0;
      end else begin
        busy_cnt = '0;
      end
      d.cpu_off = (idle_cnt > off_ticks) && (cpus > 1);
      d.cpu_on  = (busy_cnt > 1) && (cpus < MaxCpus);
      if ((idle_cnt > stby_ticks) && (cpus > 0) && (conns == '0)) begin
        d.standby = 1'b1;
        idle_cnt  = '0;
        busy_cnt  = '0;
      end
      decisions_due.push_back(d);
    endfunction

    function void report_field(string name, logic [LoadWidth-1:0] want,
                               logic [LoadWidth-1:0] got);
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 40)
          $display("%0t: %s expected %0d got %0d", $time, name, want, got);
        else if (mismatches == 41)
          $display("%0t: further mismatches not shown", $time);
      end
    endfunction

    function void check_decision(decision_t got);
      decision_t want;
      if (decisions_due.size() == 0) begin
        mismatches++;
        $display("%0t: result with no tick outstanding, expected none got load %0d",
                 $time, got.load);
        return;
      end
      want = decisions_due.pop_front();
      report_field("load_percent", want.load, got.load);
      report_field("cpu_off_request", want.cpu_off, got.cpu_off);
      report_field("cpu_on_request", want.cpu_on, got.cpu_on);
      report_field("standby_request", want.standby, got.standby);
      report_field("zero_interval", want.zero, got.zero);
    endfunction
  endclass

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    cfg_write;
  logic [CfgIdxWidth-1:0]  cfg_index;
  logic [CfgDataWidth-1:0] cfg_data;
  logic                    in_valid;
  logic                    in_stall;
  logic [CountWidth-1:0]   total_count;
  logic [CountWidth-1:0]   busy_count;
  logic [CpuWidth-1:0]     cpus_online;
  logic [ConnWidth-1:0]    connection_count;
  logic                    out_valid;
  logic                    out_stall;
  logic [LoadWidth-1:0]    load_percent;
  logic                    cpu_off_request;
  logic                    cpu_on_request;
  logic                    standby_request;
  logic                    zero_interval;

  governor_scoreboard  sb;
  bit [CountWidth-1:0] cur_total;
  bit [CountWidth-1:0] cur_busy;
  bit                  rx_quiet = 1'b0;
  bit                  force_holdoff = 1'b0;
  bit                  gaps_on = 1'b0;
  int unsigned         burst_left = 0;

  cpu_load_power_governor DUT (
    .clk              (clk),
    .rst              (rst),
    .cfg_write        (cfg_write),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .total_count      (total_count),
    .busy_count       (busy_count),
    .cpus_online      (cpus_online),
    .connection_count (connection_count),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .load_percent     (load_percent),
    .cpu_off_request  (cpu_off_request),
    .cpu_on_request   (cpu_on_request),
    .standby_request  (standby_request),
    .zero_interval    (zero_interval)
  );

  always #5 clk = ~clk;

  // Result monitor
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_decision({load_percent, cpu_off_request, cpu_on_request,
                         standby_request, zero_interval});
  end

  // Offer one tick and hold it until the transaction completes
  task automatic send_tick(input bit [CountWidth-1:0] total, input bit [CountWidth-1:0] busy,
                           input bit [CpuWidth-1:0] cpus, input bit [ConnWidth-1:0] conns);
    @(negedge clk);
    in_valid         <= 1'b1;
    total_count      <= total;
    busy_count       <= busy;
    cpus_online      <= cpus;
    connection_count <= conns;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_tick(total, busy, cpus, conns);
    cur_total = total;
    cur_busy  = busy;
  endtask

  task automatic step_by(input bit [CountWidth-1:0] dt, input bit [CountWidth-1:0] db,
                         input bit [CpuWidth-1:0] cpus, input bit [ConnWidth-1:0] conns);
    send_tick(cur_total + dt, cur_busy + db, cpus, conns);
  endtask

  // Stop offering and wait for every outstanding decision
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.decisions_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic put_reg(input cfg_reg_t idx, input bit [CfgDataWidth-1:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    sb.set_reg(idx, data);
  endtask

  task automatic apply_setting(input bit [15:0] low, input bit [15:0] high,
                               input bit [15:0] off, input bit [15:0] stby);
    wait_drained();
    put_reg(REG_LOW_THRESHOLD, low);
    put_reg(REG_HIGH_THRESHOLD, high);
    put_reg(REG_OFFLINE_IDLE_TICKS, off);
    put_reg(REG_STANDBY_IDLE_TICKS, stby);
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // Sender bursts with random gaps
  task automatic pace();
    int unsigned gap;
    if (!gaps_on) return;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 20);
      repeat (gap) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
      burst_left = $urandom_range(1, 25);
    end
    burst_left--;
  endtask

  function automatic bit [CountWidth-1:0] pick_span();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 7) return 64'($urandom_range(100, 1000000));
    if (r < 9) return {$urandom, $urandom};
    return 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 1000));
  endfunction

  // Busy delta giving roughly pct percent of span
  function automatic bit [CountWidth-1:0] busy_share(bit [CountWidth-1:0] span,
                                                     int unsigned pct);
    bit [127:0] p;
    p = ({64'd0, span} * 128'(pct)) / 128'd100;
    return p[63:0];
  endfunction

  // Receiver stall patterns
  initial begin : receiver
    int unsigned kind, span, pct, on_len, off_len, k;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (rx_quiet) begin
        @(negedge clk);
        out_stall <= 1'b0;
      end else begin
        kind = force_holdoff ? 39 : $urandom_range(0, 39);
        force_holdoff = 1'b0;
        span = $urandom_range(4, 60);
        on_len  = $urandom_range(1, 4);
        off_len = $urandom_range(1, 6);
        pct = $urandom_range(10, 80);
        if (kind == 39) begin
          // long hold-off so the block backs up into its input
          span = $urandom_range(250, 400);
          repeat (span) begin
            @(negedge clk);
            out_stall <= 1'b1;
          end
        end else if (kind < 12) begin
          repeat (span) begin
            @(negedge clk);
            out_stall <= 1'b0;
          end
        end else if (kind < 26) begin
          repeat (span) begin
            @(negedge clk);
            out_stall <= ($urandom_range(1, 100) <= pct);
          end
        end else begin
          for (k = 0; k < span; k++) begin
            @(negedge clk);
            out_stall <= ((k % (on_len + off_len)) < on_len);
          end
        end
      end
    end
  end

  // Stimulus
  initial begin : stimulus
    int unsigned         phase, n_items, regime_left, random_sent, i, pct, guard;
    regime_t             regime;
    bit [CountWidth-1:0] dt, db;
    bit [CpuWidth-1:0]   cpus;
    bit [ConnWidth-1:0]  conns;
    bit [15:0]           low, high, off, stby;
    sb = new();
    cfg_write        = 1'b0;
    cfg_index        = REG_LOW_THRESHOLD;
    cfg_data         = '0;
    in_valid         = 1'b0;
    total_count      = '0;
    busy_count       = '0;
    cpus_online      = '0;
    connection_count = '0;
    out_stall        = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: priming, zero delta, threshold edges, saturation of load, wrap
    send_tick(64'd1000, 64'd400, 2'd2, 5'd0);
    send_tick(64'd1000, 64'd900, 2'd2, 5'd0);
    step_by(64'd1000, 64'd333, 2'd1, 5'd3);
    step_by(64'd1000, 64'd1000, 2'd0, 5'd1);
    step_by(64'd500, 64'd800, 2'd3, 5'd0);
    step_by(64'd1000, 64'd50, 2'd2, 5'd0);
    step_by(64'd1000, 64'd40, 2'd2, 5'd0);
    step_by(64'd1000, 64'd100, 2'd1, 5'd0);
    step_by(64'd1000, 64'd110, 2'd1, 5'd0);
    step_by(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFE, 2'd3, 5'd31);
    send_tick(64'hFFFF_FFFF_FFFF_FF00, 64'hFFFF_FFFF_FFFF_FFF0, 2'd0, 5'd20);
    send_tick(64'h0000_0000_0000_0100, 64'h0000_0000_0000_0010, 2'd2, 5'd0);
    send_tick(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 2'd3, 5'd31);
    send_tick(64'd0, 64'd0, 2'd0, 5'd0);
    // idle streak to offline then standby, busy streak to online
    apply_setting(16'd50, 16'd60, 16'd1, 16'd3);
    repeat (4) step_by(64'd1000, 64'd10, 2'd2, 5'd0);
    repeat (3) step_by(64'd1000, 64'd900, 2'd1, 5'd5);
    step_by(64'd1000, 64'd900, 2'd0, 5'd0);
    step_by(64'd1000, 64'd550, 2'd2, 5'd0);

    // Long idle and busy streaks back to back, receiver never stalls
    rx_quiet = 1'b1;
    apply_setting(16'd1, 16'd100, 16'd65534, 16'd65535);
    repeat (40)
      send_tick(cur_total, cur_busy + 64'($urandom_range(0, 3)),
                2'($urandom_range(0, 3)), 5'($urandom));
    apply_setting(16'd0, 16'd99, 16'd65535, 16'd65535);
    repeat (40) begin
      dt = 64'($urandom_range(1, 3));
      step_by(dt, dt + 64'($urandom_range(0, 2)), 2'($urandom_range(0, 3)), 5'($urandom));
    end

    // Random phases, each under its own setting
    rx_quiet      = 1'b0;
    force_holdoff = 1'b1;
    phase         = 0;
    random_sent   = 0;
    regime_left   = 0;
    regime        = RG_MID;
    while (random_sent < 1200) begin
      case (phase)
        0: apply_setting(LowDefault, HighDefault, OffDefault, StbyDefault);
        1: apply_setting(16'd0, 16'd0, 16'd0, 16'd0);
        2: apply_setting(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        default: begin
          low  = {9'($urandom), 7'($urandom_range(0, 110))};
          high = {9'($urandom), 7'($urandom_range(0, 110))};
          off  = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 12));
          stby = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 30));
          apply_setting(low, high, off, stby);
        end
      endcase
      gaps_on = ($urandom_range(0, 3) != 0);
      n_items = $urandom_range(60, 140);
      for (i = 0; i < n_items; i++) begin
        if ($urandom_range(0, 199) == 0) wait_drained();
        pace();
        if (regime_left == 0) begin
          pct = $urandom_range(0, 99);
          if (pct < 35)      regime = RG_IDLE;
          else if (pct < 60) regime = RG_BUSY;
          else if (pct < 75) regime = RG_MID;
          else if (pct < 88) regime = RG_ZERO;
          else               regime = RG_NOISE;
          regime_left = $urandom_range(1, 50);
        end
        regime_left--;
        cpus  = 2'($urandom_range(0, 3));
        conns = ($urandom_range(0, 2) == 0) ? 5'($urandom) : 5'd0;
        dt    = pick_span();
        case (regime)
          RG_IDLE: begin
            pct = (sb.low_thr == 0) ? 0 :
                  $urandom_range(0, (sb.low_thr > 100) ? 100 : sb.low_thr - 1);
            step_by(dt, busy_share(dt, pct), cpus, conns);
          end
          RG_BUSY: begin
            pct = (sb.high_thr >= 100) ? 100 : $urandom_range(sb.high_thr + 1, 100);
            db  = busy_share(dt, pct);
            if (pct == 100 && $urandom_range(0, 1) == 1) db = db + 64'($urandom_range(0, 50));
            step_by(dt, db, cpus, conns);
          end
          RG_MID:  step_by(dt, busy_share(dt, $urandom_range(0, 100)), cpus, conns);
          RG_ZERO: step_by(64'd0, {$urandom, $urandom}, cpus, conns);
          default: send_tick({$urandom, $urandom}, {$urandom, $urandom}, cpus, 5'($urandom));
        endcase
        random_sent++;
      end
      phase++;
    end

    // Drain and finish
    @(negedge clk);
    in_valid <= 1'b0;
    guard = 0;
    while (sb.decisions_due.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (30) @(posedge clk);
    if (sb.decisions_due.size() != 0) begin
      sb.mismatches++;
      $display("%0t: %0d results never arrived", $time, sb.decisions_due.size());
    end
    if (sb.mismatches == 0) begin
      $display("** cpu_load_power_governor: PASSED **");
    end else begin
      $display("** cpu_load_power_governor: FAILED **");
    end
    $finish;
  end

  // Run limit
  initial begin : watchdog
    #50_000_000;
    $display("** cpu_load_power_governor: FAILED **");
    $finish;
  end

endmodule
